// ===== src/sppd_pkg.sv =====
package sppd_pkg;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FRAME = 1'b1
  } result_kind_t;

  localparam logic [15:0] POS_MARKER        = 16'd6;
  localparam logic [15:0] POS_MODE_TAG      = 16'd15;
  localparam logic [15:0] FIRST_SAMPLE_BYTE = 16'd17;
  localparam logic [15:0] POS_LAST          = 16'hFFFF;

  localparam logic [2:0] MARKER_LINE      = 3'd1;
  localparam logic [2:0] MARKER_MODE      = 3'd3;
  localparam logic [2:0] MARKER_FRAME_END = 3'd5;

  localparam logic [5:0] GOOD_TAG = 6'd21;

  localparam logic [9:0] MAX_SAMPLES = 10'd814;

  // value / 16384000 = (value >> 17) / 125
  localparam logic [23:0] SAT_LIMIT = 24'd8192000;  // 65536 * 125
  localparam logic [23:0] RECIP_125 = 24'd8589935;  // ceil(2^30 / 125)
  localparam int          RECIP_SHIFT = 30;

  // sign/exponent/significand word to clamped integer pixel
  function automatic logic [15:0] decode_pixel(input logic [7:0] hi, input logic [7:0] lo);
    logic [9:0]  sig;
    logic [4:0]  expo;
    logic [40:0] shifted;
    logic [23:0] scaled;
    logic [46:0] prod;
    logic [15:0] q;
    sig     = {hi[1:0], lo};
    expo    = hi[6:2];
    shifted = {31'b0, sig} << expo;
    scaled  = shifted[40:17];
    prod    = {24'b0, scaled[22:0]} * {23'b0, RECIP_125};
    q       = prod[RECIP_SHIFT+15:RECIP_SHIFT];
    if (hi[7]) begin
      decode_pixel = 16'd0;
    end else if (scaled >= SAT_LIMIT) begin
      decode_pixel = 16'hFFFF;
    end else begin
      decode_pixel = q;
    end
  endfunction

endpackage

// ===== src/scatterometer_packet_pixel_decoder.sv =====
// Channel  Handshake             Payload
// -------  --------------------  -----------------------------------------------
// in       in_valid / in_ready   data_byte, packet_end, packet_length
// out      out_valid / out_ready result_kind, channel, line_index, column_index,
//                                pixel_value, polarization_set, image_number
// cfg      cfg_valid / cfg_ready cfg_data (samples_per_line)
//
// One byte per cycle sustained while out_ready is high: a byte is held in the input
// register, then its decode (shift, reciprocal multiply, clamp) and the packet state
// update land in the output register once that register is free to advance.
// Reset (rst, synchronous) clears packet state, counters and both valid flags;
// samples_per_line returns to 814. When out_ready is low the output register
// holds and the input register fills; in_ready drops only with both full.
module scatterometer_packet_pixel_decoder #(
  parameter int MAX_LINES        = 4096,
  parameter int MIN_PACKET_BYTES = 1645
) (
  input  logic                  clk,
  input  logic                  rst,
  // byte stream
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  packet_end,
  input  logic [15:0]           packet_length,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output sppd_pkg::result_kind_t result_kind,
  output logic                  channel,
  output logic [11:0]           line_index,
  output logic [9:0]            column_index,
  output logic [15:0]           pixel_value,
  output logic                  polarization_set,
  output logic [15:0]           image_number,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [9:0]            cfg_data
);
  import sppd_pkg::*;

  // line counter saturates at min(MAX_LINES-1, 4095)
  localparam logic [11:0] LINE_CAP = ((MAX_LINES - 1) > 4095) ? 12'd4095 : 12'(MAX_LINES - 1);
  localparam logic [15:0] MIN_LEN  = 16'(MIN_PACKET_BYTES);

  // configuration register
  logic [9:0] samples_per_line;
  logic [9:0] spl;

  // input register
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_end;
  logic [15:0] s1_len;

  // packet state
  logic [15:0] byte_position, byte_position_next;
  logic        packet_valid, packet_valid_next;
  logic [2:0]  current_marker, current_marker_next;
  logic [2:0]  previous_marker, previous_marker_next;
  logic [5:0]  mode_tag, mode_tag_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [11:0] line_count, line_count_next;
  logic [15:0] image_count, image_count_next;

  // result of the byte in the input register
  logic         res_valid;
  result_kind_t res_kind;
  logic         res_channel;
  logic [11:0]  res_line;
  logic [9:0]   res_column;
  logic [15:0]  res_pixel;
  logic         res_pol;
  logic [15:0]  res_image;

  logic        advance;
  logic        s1_fire;
  logic        pkt_ok;
  logic [15:0] sample_off;
  logic [14:0] col;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign s1_fire   = s1_valid && advance;
  assign in_ready  = !s1_valid || advance;

  // out-of-range register values fold into 1..814
  always_comb begin
    if (samples_per_line == 10'd0) begin
      spl = 10'd1;
    end else if (samples_per_line > MAX_SAMPLES) begin
      spl = MAX_SAMPLES;
    end else begin
      spl = samples_per_line;
    end
  end

  assign sample_off = byte_position - FIRST_SAMPLE_BYTE;
  assign col        = sample_off[15:1];

  always_comb begin
    byte_position_next   = byte_position;
    current_marker_next  = current_marker;
    previous_marker_next = previous_marker;
    mode_tag_next        = mode_tag;
    high_byte_hold_next  = high_byte_hold;
    line_count_next      = line_count;
    image_count_next     = image_count;
    res_valid   = 1'b0;
    res_kind    = KIND_PIXEL;
    res_channel = 1'b0;
    res_line    = 12'd0;
    res_column  = 10'd0;
    res_pixel   = 16'd0;
    res_pol     = 1'b0;
    res_image   = 16'd0;

    // length check happens on byte 0 only
    pkt_ok = (byte_position == 16'd0) ? (s1_len >= MIN_LEN) : packet_valid;
    packet_valid_next = pkt_ok;

    if (pkt_ok) begin
      if (byte_position == POS_MARKER) begin
        current_marker_next  = s1_byte[5:3];
        previous_marker_next = s1_byte[5:3];
        // marker 5 then marker 1: frame closes
        if (previous_marker == MARKER_FRAME_END && s1_byte[5:3] == MARKER_LINE) begin
          res_valid = 1'b1;
          res_kind  = KIND_FRAME;
          res_line  = line_count;
          if (mode_tag == GOOD_TAG) begin
            image_count_next = image_count + 16'd1;
            res_pol          = 1'b0;
          end else begin
            res_pol          = 1'b1;
          end
          res_image       = image_count_next;
          line_count_next = 12'd0;
        end
      end else if (byte_position == POS_MODE_TAG) begin
        if (current_marker == MARKER_MODE) begin
          mode_tag_next = s1_byte[7:2];
        end
      end else if (byte_position >= FIRST_SAMPLE_BYTE && current_marker <= MARKER_LINE) begin
        if (!sample_off[0]) begin
          high_byte_hold_next = s1_byte;
        end else if (col < {5'b0, spl}) begin
          res_valid   = 1'b1;
          res_kind    = KIND_PIXEL;
          res_channel = current_marker[0];
          res_line    = line_count;
          res_column  = col[9:0];
          res_pixel   = decode_pixel(high_byte_hold, s1_byte);
          // last sample of a marker-1 packet ends a line
          if (col[9:0] == spl - 10'd1 && current_marker == MARKER_LINE &&
              line_count < LINE_CAP) begin
            line_count_next = line_count + 12'd1;
          end
        end
      end
    end

    if (s1_end) begin
      byte_position_next = 16'd0;
    end else if (byte_position != POS_LAST) begin
      byte_position_next = byte_position + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_line <= MAX_SAMPLES;
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      byte_position    <= 16'd0;
      packet_valid     <= 1'b0;
      current_marker   <= 3'd0;
      previous_marker  <= 3'd0;
      mode_tag         <= 6'd0;
      high_byte_hold   <= 8'd0;
      line_count       <= 12'd0;
      image_count      <= 16'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        samples_per_line <= cfg_data;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid && res_valid;
      end
      if (s1_fire) begin
        byte_position   <= byte_position_next;
        packet_valid    <= packet_valid_next;
        current_marker  <= current_marker_next;
        previous_marker <= previous_marker_next;
        mode_tag        <= mode_tag_next;
        high_byte_hold  <= high_byte_hold_next;
        line_count      <= line_count_next;
        image_count     <= image_count_next;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= data_byte;
      s1_end  <= packet_end;
      s1_len  <= packet_length;
    end
    if (advance) begin
      result_kind      <= res_kind;
      channel          <= res_channel;
      line_index       <= res_line;
      column_index     <= res_column;
      pixel_value      <= res_pixel;
      polarization_set <= res_pol;
      image_number     <= res_image;
    end
  end

  // back-pressure only when both stages hold a transaction
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid))
    else $error("in_ready low with a free stage");

  assert property (@(posedge clk) disable iff (rst)
    line_count <= LINE_CAP)
    else $error("line count past its cap");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_PIXEL |-> column_index < MAX_SAMPLES && !polarization_set)
    else $error("pixel transaction with bad column or frame fields");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_FRAME |-> column_index == 10'd0 && pixel_value == 16'd0)
    else $error("frame transaction with pixel fields set");

  // a frame event restarts line counting
  assert property (@(posedge clk) disable iff (rst)
    advance && s1_valid && res_valid && res_kind == KIND_FRAME |=> line_count == 12'd0)
    else $error("line count not cleared after frame event");

endmodule

// ===== verif/scatterometer_packet_pixel_decoder_test.sv =====
module scatterometer_packet_pixel_decoder_test;
  import sppd_pkg::*;

  // Same values as the block's defaults, passed down explicitly.
  localparam int MAX_LINES        = 4096;
  localparam int MIN_PACKET_BYTES = 1645;

  // Line counter ceiling: the smaller of MAX_LINES-1 and the 12-bit limit.
  localparam logic [11:0] LINE_CAP = (MAX_LINES - 1 > 4095) ? 12'd4095 : 12'(MAX_LINES - 1);

  // sig * 2^(e-15) / 500 == sig * 2^e / (500 * 2^15)
  localparam logic [63:0] PIXEL_DIVISOR = 64'd16384000;

  // Cycles with no transaction on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;

  // Quiet cycles required before a register write or the final verdict;
  // the pipe is two deep, so this covers bytes that produce no result.
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    logic [15:0] length;
  } stream_byte_t;

  typedef struct packed {
    result_kind_t kind;
    logic         chan;
    logic [11:0]  line;
    logic [9:0]   col;
    logic [15:0]  pix;
    logic         pol;
    logic [15:0]  img;
  } decoded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic         in_valid      = 1'b0;
  logic         in_ready;
  logic [7:0]   data_byte     = '0;
  logic         packet_end    = 1'b0;
  logic [15:0]  packet_length = '0;

  logic         out_valid;
  logic         out_ready     = 1'b0;
  result_kind_t result_kind;
  logic         channel;
  logic [11:0]  line_index;
  logic [9:0]   column_index;
  logic [15:0]  pixel_value;
  logic         polarization_set;
  logic [15:0]  image_number;

  logic         cfg_valid     = 1'b0;
  logic         cfg_ready;
  logic [9:0]   cfg_data      = '0;

  scatterometer_packet_pixel_decoder #(
    .MAX_LINES       (MAX_LINES),
    .MIN_PACKET_BYTES(MIN_PACKET_BYTES)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .packet_end      (packet_end),
    .packet_length   (packet_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .channel         (channel),
    .line_index      (line_index),
    .column_index    (column_index),
    .pixel_value     (pixel_value),
    .polarization_set(polarization_set),
    .image_number    (image_number),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared state between stimulus, driver, monitor
  // ---------------------------------------------------------------------------
  stream_byte_t pending_bytes[$];  // bytes waiting to be driven
  decoded_t     decoded_q[$];      // predicted results, oldest first
  int           mismatch_count = 0;
  int           live_bytes = 0;    // bytes sent in packets long enough to be decoded
  bit           no_idle = 1'b0;    // both sides run flat out while set

  // Predictor's copy of the block state and the register.
  logic [9:0]  spl_reg     = MAX_SAMPLES;
  logic [15:0] byte_pos    = '0;
  logic        pkt_ok      = 1'b0;
  logic [2:0]  cur_marker  = '0;
  logic [2:0]  prev_marker = '0;
  logic [5:0]  mode_tag    = '0;
  logic [7:0]  high_hold   = '0;
  logic [11:0] line_count  = '0;
  logic [15:0] image_count = '0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Register clamp: 0 behaves as 1, anything past 814 as 814.
  function automatic logic [9:0] active_samples();
    if (spl_reg == 10'd0) begin
      return 10'd1;
    end else if (spl_reg > MAX_SAMPLES) begin
      return MAX_SAMPLES;
    end
    return spl_reg;
  endfunction

  // Sign / 5-bit exponent / 10-bit significand to a clamped integer pixel.
  // Negative samples clamp to 0; large ones saturate.
  function automatic logic [15:0] pixel_from_word(input logic [7:0] hi, input logic [7:0] lo);
    logic [63:0] mag;
    logic [63:0] quot;
    if (hi[7]) begin
      return 16'd0;
    end
    mag  = {54'd0, hi[1:0], lo} << hi[6:2];
    quot = mag / PIXEL_DIVISOR;
    return (quot > 64'd65535) ? 16'hFFFF : quot[15:0];
  endfunction

  // Advance the predictor by one accepted byte; queue any result it causes.
  task automatic decode_byte(input stream_byte_t it);
    logic [15:0] at;
    logic [15:0] off;
    logic [15:0] col;
    logic [9:0]  spl;
    logic [2:0]  m;
    decoded_t    r;
    at  = byte_pos;
    spl = active_samples();
    r.kind = KIND_PIXEL;
    r.chan = 1'b0;
    r.line = '0;
    r.col  = '0;
    r.pix  = '0;
    r.pol  = 1'b0;
    r.img  = '0;

    // Length is trusted and judged once, at byte 0.
    if (at == 16'd0) begin
      pkt_ok = (it.length >= MIN_PACKET_BYTES);
    end

    if (pkt_ok) begin
      if (at == POS_MARKER) begin
        m = it.data[5:3];
        cur_marker = m;
        // Line packet right after a frame-end packet closes the frame.
        if (prev_marker == MARKER_FRAME_END && m == MARKER_LINE) begin
          r.kind = KIND_FRAME;
          r.line = line_count;
          if (mode_tag == GOOD_TAG) begin
            image_count = image_count + 16'd1;
            r.pol = 1'b0;
          end else begin
            r.pol = 1'b1;
          end
          r.img = image_count;
          decoded_q.push_back(r);
          line_count = '0;
        end
        prev_marker = m;
      end else if (at == POS_MODE_TAG) begin
        if (cur_marker == MARKER_MODE) begin
          mode_tag = it.data[7:2];
        end
      end else if (at >= FIRST_SAMPLE_BYTE && cur_marker <= MARKER_LINE) begin
        off = at - FIRST_SAMPLE_BYTE;
        if (!off[0]) begin
          high_hold = it.data;
        end else begin
          col = off >> 1;
          if (col < {6'd0, spl}) begin
            r.kind = KIND_PIXEL;
            r.chan = cur_marker[0];
            r.line = line_count;
            r.col  = col[9:0];
            r.pix  = pixel_from_word(high_hold, it.data);
            decoded_q.push_back(r);
            // Only a line packet that reached its last sample counts a line.
            if (col == {6'd0, spl - 10'd1} && cur_marker == MARKER_LINE &&
                line_count < LINE_CAP) begin
              line_count = line_count + 12'd1;
            end
          end
        end
      end
    end

    if (it.last) begin
      byte_pos = '0;
    end else if (byte_pos != POS_LAST) begin
      byte_pos = byte_pos + 16'd1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("error: %s", msg);
    end
  endtask

  function automatic string show(input decoded_t r);
    return $sformatf("kind=%0d ch=%0d line=%0d col=%0d pix=%0d pol=%0d img=%0d",
                     r.kind, r.chan, r.line, r.col, r.pix, r.pol, r.img);
  endfunction

  // ---------------------------------------------------------------------------
  // Idle gaps: mostly none or short, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end else if (pick < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued bytes, predicts on each input transaction
  // ---------------------------------------------------------------------------
  stream_byte_t cur_byte;
  int           send_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_byte(cur_byte);
      end
      // Free to change the payload only when nothing is held or it just went.
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          cur_byte = pending_bytes.pop_front();
          data_byte     <= cur_byte.data;
          packet_end    <= cur_byte.last;
          packet_length <= cur_byte.length;
          in_valid      <= 1'b1;
          send_gap = no_idle ? 0 : idle_length();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each output transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  decoded_t got;
  decoded_t want;
  int       stall_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.kind = result_kind;
        got.chan = channel;
        got.line = line_index;
        got.col  = column_index;
        got.pix  = pixel_value;
        got.pol  = polarization_set;
        got.img  = image_number;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %s", show(got)));
        end else begin
          want = decoded_q.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf("got %s, want %s", show(got), show(want)));
          end
        end
      end
      if (no_idle) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 7) == 0) begin
          stall_left = idle_length() + 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transaction means the block is stuck
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("scatterometer_packet_pixel_decoder: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Wait until every byte is in, every result is out, and the pipe has settled.
  task automatic drain();
    int quiet;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk);
      if (pending_bytes.size() == 0 && !in_valid && decoded_q.size() == 0) begin
        quiet++;
      end else begin
        quiet = 0;
      end
    end
  endtask

  // Register write, only with the block idle.
  task automatic write_spl(input logic [9:0] value);
    drain();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    spl_reg = value;
    cfg_valid <= 1'b0;
  endtask

  // High sample byte: random, with a bias toward big exponents so the
  // saturation path gets exercised.
  function automatic logic [7:0] sample_high();
    logic [31:0] rnd;
    rnd = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      return {1'b0, 5'($urandom_range(26, 31)), rnd[1:0]};
    end
    return rnd[7:0];
  endfunction

  function automatic logic [15:0] valid_length();
    return 16'($urandom_range(MIN_PACKET_BYTES, 65535));
  endfunction

  // Bytes in a complete line packet at the current register setting.
  function automatic int line_bytes();
    return FIRST_SAMPLE_BYTE + 2 * active_samples();
  endfunction

  // Queue one packet. Marker goes into byte 6, the tag into byte 15 of a
  // mode packet; samples are random or all equal to word when fixed is set.
  // Byte position is taken modulo 2^16 so that an overlong packet carries a
  // second marker at the would-be wrapped byte 6.
  task automatic add_packet(input logic [15:0] decl_len, input int nbytes,
                            input logic [2:0] marker, input logic [5:0] tag,
                            input bit fixed, input logic [15:0] word);
    stream_byte_t item;
    logic [31:0]  rnd;
    logic [15:0]  p;
    logic [15:0]  off;
    item.length = decl_len;
    for (int i = 0; i < nbytes; i++) begin
      rnd = $urandom;
      p = i[15:0];
      item.last = (i == nbytes - 1);
      if (p == POS_MARKER) begin
        item.data = {rnd[7:6], marker, rnd[2:0]};
      end else if (p == POS_MODE_TAG && marker == MARKER_MODE) begin
        item.data = {tag, rnd[1:0]};
      end else if (p >= FIRST_SAMPLE_BYTE) begin
        off = p - FIRST_SAMPLE_BYTE;
        if (!off[0]) begin
          item.data = fixed ? word[15:8] : sample_high();
        end else begin
          item.data = fixed ? word[7:0] : rnd[7:0];
        end
      end else begin
        item.data = rnd[7:0];
      end
      pending_bytes.push_back(item);
    end
    if (decl_len >= MIN_PACKET_BYTES) begin
      live_bytes += nbytes;
    end
  endtask

  // Well-formed frame: optional mode packet, a few line packets, then the
  // frame-end / line pair that raises the frame event.
  task automatic add_frame();
    logic [5:0] tag;
    tag = ($urandom_range(0, 9) < 6) ? GOOD_TAG : 6'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      add_packet(valid_length(), $urandom_range(16, 20), MARKER_MODE, tag, 1'b0, '0);
    end
    repeat ($urandom_range(1, 4)) begin
      add_packet(valid_length(), line_bytes() + $urandom_range(0, 3),
                 3'($urandom_range(0, 1)), '0, 1'b0, '0);
    end
    add_packet(valid_length(), $urandom_range(7, 24), MARKER_FRAME_END, '0, 1'b0, '0);
    add_packet(valid_length(), line_bytes(), MARKER_LINE, '0, 1'b0, '0);
  endtask

  // Noise: any marker, any length, often cut short or declared too short.
  task automatic add_noise();
    logic [15:0] len;
    len = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, MIN_PACKET_BYTES - 1))
                                      : valid_length();
    add_packet(len, $urandom_range(1, line_bytes() + 4), 3'($urandom), 6'($urandom),
               1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  int target;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: one sample per packet keeps these short.
    write_spl(10'd1);
    @(negedge clk);
    // declared one byte too short: ignored entirely
    add_packet(16'(MIN_PACKET_BYTES - 1), 19, 3'd0, '0, 1'b1, 16'h3C00);
    add_packet(16'(MIN_PACKET_BYTES), 16, MARKER_MODE, GOOD_TAG, 1'b0, '0);
    // largest exponent and significand: saturates
    add_packet(16'hFFFF, 19, 3'd0, '0, 1'b1, 16'h7FFF);
    // sign set: clamps to zero; line packet counts a line
    add_packet(16'(MIN_PACKET_BYTES), 19, MARKER_LINE, '0, 1'b1, 16'hFFFF);
    add_packet(16'(MIN_PACKET_BYTES), 19, 3'd0, '0, 1'b1, 16'h0000);
    // frame close with the good tag, then a line packet cut before its sample
    add_packet(16'(MIN_PACKET_BYTES), 7, MARKER_FRAME_END, '0, 1'b0, '0);
    add_packet(16'(MIN_PACKET_BYTES), 18, MARKER_LINE, '0, 1'b1, 16'h7C00);
    // frame close with another tag: second polarization set, no count
    add_packet(16'(MIN_PACKET_BYTES), 16, MARKER_MODE, 6'd7, 1'b0, '0);
    add_packet(16'(MIN_PACKET_BYTES), 7, MARKER_FRAME_END, '0, 1'b0, '0);
    add_packet(16'(MIN_PACKET_BYTES), 19, MARKER_LINE, '0, 1'b1, 16'h03FF);

    // Register above range acts as 814; a short packet of pixels.
    write_spl(10'h3FF);
    @(negedge clk);
    add_packet(16'(MIN_PACKET_BYTES), 41, 3'd0, '0, 1'b0, '0);

    // Largest legal setting, packet cut off on a high byte.
    write_spl(MAX_SAMPLES);
    @(negedge clk);
    add_packet(16'hFFFF, 30, 3'd0, '0, 1'b0, '0);

    // Random phases at small settings; the drain before each write is
    // where the sender holds off until every result has come back.
    for (int ph = 0; ph < 4; ph++) begin
      write_spl((ph == 0) ? 10'd2 : 10'($urandom_range(1, 6)));
      @(negedge clk);
      no_idle = (ph == 3);
      target = live_bytes + 220;
      while (live_bytes < target) begin
        if ($urandom_range(0, 9) < 7) begin
          add_frame();
        end else begin
          add_noise();
        end
      end
    end

    // Register 0 acts as 1; a run of line packets reported through a
    // frame event.
    write_spl(10'd0);
    @(negedge clk);
    no_idle = 1'b1;
    repeat (5) begin
      add_packet(16'(MIN_PACKET_BYTES), 19, MARKER_LINE, '0, 1'b0, '0);
    end
    add_packet(16'(MIN_PACKET_BYTES), 7, MARKER_FRAME_END, '0, 1'b0, '0);
    add_packet(16'(MIN_PACKET_BYTES), 19, MARKER_LINE, '0, 1'b0, '0);
    drain();
    no_idle = 1'b0;

    // Short closing phase with idling back on.
    write_spl(10'd4);
    @(negedge clk);
    repeat (3) add_frame();
    drain();

    if (mismatch_count == 0) begin
      $display("scatterometer_packet_pixel_decoder: match");
    end else begin
      $display("scatterometer_packet_pixel_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/sppd_pkg.sv
src/scatterometer_packet_pixel_decoder.sv
verif/scatterometer_packet_pixel_decoder_test.sv
